// ----- rtl/orl_pkg.sv -----
// ============================================================================
// orl_pkg
// Shared types, field widths and codes for the ordered record list.
// ============================================================================
package orl_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int OP_W  = 2;
    localparam int POS_W = 7;
    localparam int KEY_W = 32;
    localparam int PAY_W = 32;
    localparam int ST_W  = 2;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_POS   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [POS_W-1:0]        position;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic [IDX_W-1:0]        index;
        logic signed [KEY_W-1:0] found_key;
        logic [PAY_W-1:0]        found_payload;
        logic [CNT_W-1:0]        count_after;
        logic                    last;
    } t_res;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic                    ins;        // open a slot at 'at' and load key/pay
        logic                    del;        // close the slot at 'at'
        logic                    tok_load;   // place the scan token in cell zero
        logic                    tok_shift;  // move the scan token one cell up
        logic [POS_W-1:0]        at;
        logic [POS_W-1:0]        count;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        pay;
    } t_cell_ctl;

    function automatic t_res mk_fail(input logic [ST_W-1:0] st,
                                     input logic [CNT_W-1:0] cnt);
        t_res r;
        r               = '0;
        r.status        = st;
        r.count_after   = cnt;
        r.last          = 1'b1;
        return r;
    endfunction

endpackage

// ----- rtl/orl_cell.sv -----
// ============================================================================
// orl_cell
// One slot of the record chain: holds a key, a payload and a scan token bit.
// ============================================================================
module orl_cell #(
    parameter int IDX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  orl_pkg::t_cell_ctl               i_ctl,
    input  logic signed [orl_pkg::KEY_W-1:0] i_left_key,
    input  logic [orl_pkg::PAY_W-1:0]        i_left_pay,
    input  logic signed [orl_pkg::KEY_W-1:0] i_right_key,
    input  logic [orl_pkg::PAY_W-1:0]        i_right_pay,
    input  logic                             i_tok,
    output logic signed [orl_pkg::KEY_W-1:0] o_key,
    output logic [orl_pkg::PAY_W-1:0]        o_pay,
    output logic                             o_tok,
    output logic                             o_hit,
    output logic signed [orl_pkg::KEY_W-1:0] o_sel_key,
    output logic [orl_pkg::PAY_W-1:0]        o_sel_pay
);
    import orl_pkg::*;

    localparam logic [POS_W-1:0] MY_POS  = POS_W'(IDX);
    localparam logic [POS_W-1:0] NXT_POS = POS_W'(IDX + 1);

    logic signed [KEY_W-1:0] r_key;
    logic [PAY_W-1:0]        r_pay;
    logic                    r_tok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (MY_POS > i_ctl.at && MY_POS <= i_ctl.count) begin
                r_key <= i_left_key;
                r_pay <= i_left_pay;
            end else if (MY_POS == i_ctl.at) begin
                r_key <= i_ctl.key;
                r_pay <= i_ctl.pay;
            end
        end else if (i_ctl.del) begin
            if (MY_POS >= i_ctl.at && NXT_POS < i_ctl.count) begin
                r_key <= i_right_key;
                r_pay <= i_right_pay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.tok_load) begin
            r_tok <= (IDX == 0);
        end else if (i_ctl.tok_shift) begin
            r_tok <= i_tok;
        end
    end

    assign o_key     = r_key;
    assign o_pay     = r_pay;
    assign o_tok     = r_tok;
    assign o_hit     = r_tok && (r_key == i_ctl.key);
    assign o_sel_key = r_tok ? r_key : '0;
    assign o_sel_pay = r_tok ? r_pay : '0;

endmodule

// ----- rtl/ordered_record_list_unit.sv -----
// ============================================================================
// ordered_record_list_unit
// Ordered list of records held in a chain of shift cells, with insert at a
// position, search by key and delete of the first matching key.
// ============================================================================
//
//  channel   direction  handshake                    payload
//  command   in         i_cmd_valid / o_cmd_ready    i_cmd (t_cmd)
//  result    out        o_res_valid / i_res_ready    o_res (t_res)
//
//  Insert shifts the chain open a slot in the cycle the item is accepted; its
//  result goes through the pending register into the output register.
//  Search walks a token through the chain, one cell per cycle unless a hit
//  must wait for the output register; delete stops at the first match.
//  A new item is taken only after the current one has handed its final result
//  to the output register; a stalled output holds the scan in place.
//  Reset is synchronous; it empties the list and needs no clearing pass.
//
module ordered_record_list_unit #(
    parameter int DEPTH = orl_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  orl_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output orl_pkg::t_res o_res
);
    import orl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [OP_W-1:0] r_op;
    logic signed [KEY_W-1:0] r_key;
    logic            r_pv;
    t_res            r_pend;
    logic            r_ov;
    t_res            r_o;

    t_cell_ctl ctl;

    logic signed [KEY_W-1:0] cell_key     [DEPTH];
    logic [PAY_W-1:0]        cell_pay     [DEPTH];
    logic signed [KEY_W-1:0] cell_sel_key [DEPTH];
    logic [PAY_W-1:0]        cell_sel_pay [DEPTH];
    logic [DEPTH-1:0]        tok_vec;
    logic [DEPTH-1:0]        hit_vec;

    logic signed [KEY_W-1:0] sel_key;
    logic [PAY_W-1:0]        sel_pay;
    logic                    sel_hit;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic             full;
    logic             bad_pos;
    logic             scan_end;
    logic             scan_adv;
    logic [CNT_W-1:0] cnt;
    t_res             flush_res;

    // ------------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [KEY_W-1:0] lk;
        logic signed [KEY_W-1:0] rk;
        logic [PAY_W-1:0]        lp;
        logic [PAY_W-1:0]        rp;
        logic                    lt;

        if (g == 0) begin : g_head
            assign lk = '0;
            assign lp = '0;
            assign lt = 1'b0;
        end else begin : g_body
            assign lk = cell_key[g-1];
            assign lp = cell_pay[g-1];
            assign lt = tok_vec[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign rk = '0;
            assign rp = '0;
        end else begin : g_inner
            assign rk = cell_key[g+1];
            assign rp = cell_pay[g+1];
        end

        orl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_left_key  (lk),
            .i_left_pay  (lp),
            .i_right_key (rk),
            .i_right_pay (rp),
            .i_tok       (lt),
            .o_key       (cell_key[g]),
            .o_pay       (cell_pay[g]),
            .o_tok       (tok_vec[g]),
            .o_hit       (hit_vec[g]),
            .o_sel_key   (cell_sel_key[g]),
            .o_sel_pay   (cell_sel_pay[g])
        );
    end

    // Only the cell holding the token drives a nonzero value.
    always_comb begin
        sel_key = '0;
        sel_pay = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_key = sel_key | cell_sel_key[i];
            sel_pay = sel_pay | cell_sel_pay[i];
        end
    end
    assign sel_hit = |hit_vec;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    assign o_cmd_ready = (r_state == S_IDLE);
    assign accept      = i_cmd_valid && o_cmd_ready;
    assign out_free    = !r_ov || i_res_ready;
    assign cnt         = CNT_W'(r_count);
    assign full        = (r_count == CW'(DEPTH));
    assign bad_pos     = (i_cmd.position > POS_W'(r_count));
    assign scan_end    = (r_idx == r_count);
    // A search hit can move on only once the previous hit has somewhere to go.
    assign scan_adv    = (r_state == S_SCAN) && !scan_end &&
                         (!sel_hit || (r_op == OP_SEARCH && (!r_pv || out_free)));
    // The output register takes the final result, or an earlier search hit.
    assign out_load    = ((r_state == S_FLUSH) && out_free) ||
                         (scan_adv && sel_hit && r_pv);

    always_comb begin
        flush_res      = r_pend;
        flush_res.last = 1'b1;
    end

    always_comb begin
        ctl           = '0;
        ctl.ins       = accept && (i_cmd.operation == OP_INSERT) && !full && !bad_pos;
        ctl.del       = (r_state == S_SCAN) && !scan_end && sel_hit &&
                        (r_op == OP_DELETE);
        ctl.tok_load  = accept && (i_cmd.operation == OP_SEARCH ||
                                   i_cmd.operation == OP_DELETE);
        ctl.tok_shift = scan_adv;
        ctl.at        = (r_state == S_IDLE) ? i_cmd.position : POS_W'(r_idx);
        ctl.count     = POS_W'(r_count);
        ctl.key       = (r_state == S_IDLE) ? i_cmd.key : r_key;
        ctl.pay       = i_cmd.payload;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= out_load || (r_ov && !i_res_ready);
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op  <= i_cmd.operation;
                        r_key <= i_cmd.key;
                        r_idx <= '0;
                        case (i_cmd.operation)
                            OP_INSERT: begin
                                r_pv    <= 1'b1;
                                r_state <= S_FLUSH;
                                if (full) begin
                                    r_pend <= mk_fail(ST_FULL, cnt);
                                end else if (bad_pos) begin
                                    r_pend <= mk_fail(ST_BAD_POS, cnt);
                                end else begin
                                    r_pend.status        <= ST_OK;
                                    r_pend.index         <= IDX_W'(i_cmd.position);
                                    r_pend.found_key     <= i_cmd.key;
                                    r_pend.found_payload <= i_cmd.payload;
                                    r_pend.count_after   <= cnt + 1'b1;
                                    r_pend.last          <= 1'b1;
                                    r_count              <= r_count + 1'b1;
                                end
                            end
                            OP_SEARCH, OP_DELETE: begin
                                r_pv    <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_pv    <= 1'b1;
                                r_pend  <= mk_fail(ST_NOT_FOUND, cnt);
                                r_state <= S_FLUSH;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_end) begin
                        if (!r_pv) begin
                            r_pv   <= 1'b1;
                            r_pend <= mk_fail(ST_NOT_FOUND, cnt);
                        end
                        r_state <= S_FLUSH;
                    end else if (sel_hit && r_op == OP_DELETE) begin
                        r_pend.status        <= ST_OK;
                        r_pend.index         <= IDX_W'(r_idx);
                        r_pend.found_key     <= sel_key;
                        r_pend.found_payload <= sel_pay;
                        r_pend.count_after   <= cnt - 1'b1;
                        r_pend.last          <= 1'b1;
                        r_pv                 <= 1'b1;
                        r_count              <= r_count - 1'b1;
                        r_state              <= S_FLUSH;
                    end else if (scan_adv) begin
                        r_idx <= r_idx + 1'b1;
                        if (sel_hit) begin
                            // Earlier hit is not the last one: release it now.
                            if (r_pv) begin
                                r_o <= r_pend;
                            end
                            r_pend.status        <= ST_OK;
                            r_pend.index         <= IDX_W'(r_idx);
                            r_pend.found_key     <= sel_key;
                            r_pend.found_payload <= sel_pay;
                            r_pend.count_after   <= cnt;
                            r_pend.last          <= 1'b0;
                            r_pv                 <= 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_o     <= flush_res;
                        r_pv    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_o;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds list depth");

    a_tok_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one scan token in the chain");

    a_tok_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_idx < r_count) |-> $onehot(tok_vec))
        else $error("scan token lost inside the occupied part of the chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv)
        else $error("pending result left behind when returning to idle");

    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.del |=> (r_count == $past(r_count) - 1'b1))
        else $error("delete did not shrink the list by one");

endmodule

// ----- bench/ordered_record_list_unit_tb.sv -----
// ============================================================================
// ordered_record_list_unit_tb
// Self-checking bench for the ordered record list. A mirror of the list in
// the bench predicts every result of insert, search and delete. Directed
// items cover the empty list, insert positions, duplicate keys and the
// unused opcode. Further items fill the list to full, search across all
// entries and then run random grow and shrink phases. Both handshakes idle
// at random, and some phases run with no idling.
// ============================================================================
module ordered_record_list_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import orl_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = LIST_DEPTH + 8;
    localparam int SEG_ITEMS   = 40;
    localparam int SEG_COUNT   = 9;
    localparam int MAX_GAP     = 13;

    localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MIN   = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX   = 32'h7fff_ffff;
    localparam logic [KEY_W-1:0] FILL_KEY  = 32'h1357_9bdf;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;
    logic res_valid;
    logic res_ready;
    t_res res;

    // Mirror of the list contents and the results still owed by the block.
    logic signed [KEY_W-1:0] mirror_keys [LIST_DEPTH];
    logic [PAY_W-1:0]        mirror_pays [LIST_DEPTH];
    int                      mirror_count;
    t_res                    due_results [$];

    int err_count;
    bit tx_idle;
    bit rx_idle;

    ordered_record_list_unit #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready),
        .i_cmd      (cmd),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_res miss_result(input logic [ST_W-1:0] st);
        t_res r;
        r             = '0;
        r.status      = st;
        r.count_after = mirror_count[CNT_W-1:0];
        r.last        = 1'b1;
        return r;
    endfunction

    // Updates the mirror for one accepted item and queues the results it owes.
    task automatic apply_list_op(input t_cmd c);
        t_res r;
        int   i;
        int   hits;
        int   seen;
        int   at;
        r    = '0;
        hits = 0;
        seen = 0;
        at   = -1;
        case (c.operation)
            OP_INSERT: begin
                if (mirror_count >= LIST_DEPTH) begin
                    due_results.push_back(miss_result(ST_FULL));
                end else if (int'(c.position) > mirror_count) begin
                    due_results.push_back(miss_result(ST_BAD_POS));
                end else begin
                    for (i = mirror_count; i > int'(c.position); i--) begin
                        mirror_keys[i] = mirror_keys[i-1];
                        mirror_pays[i] = mirror_pays[i-1];
                    end
                    mirror_keys[c.position] = c.key;
                    mirror_pays[c.position] = c.payload;
                    mirror_count++;
                    r.status        = ST_OK;
                    r.index         = c.position[IDX_W-1:0];
                    r.found_key     = c.key;
                    r.found_payload = c.payload;
                    r.count_after   = mirror_count[CNT_W-1:0];
                    r.last          = 1'b1;
                    due_results.push_back(r);
                end
            end
            OP_SEARCH: begin
                for (i = 0; i < mirror_count; i++) begin
                    if (mirror_keys[i] == c.key) hits++;
                end
                if (hits == 0) begin
                    due_results.push_back(miss_result(ST_NOT_FOUND));
                end else begin
                    for (i = 0; i < mirror_count; i++) begin
                        if (mirror_keys[i] == c.key) begin
                            seen++;
                            r.status        = ST_OK;
                            r.index         = i[IDX_W-1:0];
                            r.found_key     = mirror_keys[i];
                            r.found_payload = mirror_pays[i];
                            r.count_after   = mirror_count[CNT_W-1:0];
                            r.last          = (seen == hits);
                            due_results.push_back(r);
                        end
                    end
                end
            end
            OP_DELETE: begin
                for (i = 0; i < mirror_count && at < 0; i++) begin
                    if (mirror_keys[i] == c.key) at = i;
                end
                if (at < 0) begin
                    due_results.push_back(miss_result(ST_NOT_FOUND));
                end else begin
                    r.status        = ST_OK;
                    r.index         = at[IDX_W-1:0];
                    r.found_key     = mirror_keys[at];
                    r.found_payload = mirror_pays[at];
                    for (i = at; i + 1 < mirror_count; i++) begin
                        mirror_keys[i] = mirror_keys[i+1];
                        mirror_pays[i] = mirror_pays[i+1];
                    end
                    mirror_count--;
                    r.count_after = mirror_count[CNT_W-1:0];
                    r.last        = 1'b1;
                    due_results.push_back(r);
                end
            end
            default: begin
                due_results.push_back(miss_result(ST_NOT_FOUND));
            end
        endcase
    endtask

    // Valid stays high after acceptance; the next call either lowers it or
    // presents the next item in the same time step.
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do @(posedge clk); while (!(cmd_valid && cmd_ready));
        apply_list_op(c);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input int pos,
                           input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay);
        t_cmd c;
        c.operation = op;
        c.position  = pos[POS_W-1:0];
        c.key       = key;
        c.payload   = pay;
        send_cmd(c);
    endtask

    task automatic wait_for_results();
        cmd_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            3:       return '1;
            4:       return 32'd1;
            5:       return 32'h5a5a_5a5a;
            6:       return 32'ha5a5_a5a5;
            7:       return 32'd13;
            default: return $urandom;
        endcase
    endfunction

    // Mostly keys that are in the list, so that search and delete hit.
    function automatic logic [KEY_W-1:0] list_key();
        if (mirror_count > 0 && $urandom_range(0, 9) < 7)
            return mirror_keys[$urandom_range(0, mirror_count - 1)];
        return pick_key();
    endfunction

    function automatic t_cmd random_cmd(input bit grow);
        t_cmd c;
        int   roll;
        roll        = $urandom_range(0, 99);
        c.payload   = $urandom;
        c.position  = POS_W'($urandom_range(0, LIST_DEPTH));
        c.key       = list_key();
        if (roll < (grow ? 60 : 15)) begin
            c.operation = OP_INSERT;
            c.key       = pick_key();
            if ($urandom_range(0, 9) == 0 && mirror_count < LIST_DEPTH)
                c.position = POS_W'($urandom_range(mirror_count + 1, LIST_DEPTH));
            else
                c.position = POS_W'($urandom_range(0, mirror_count));
        end else if (roll < (grow ? 80 : 35)) begin
            c.operation = OP_SEARCH;
        end else if (roll < 95) begin
            c.operation = OP_DELETE;
        end else begin
            c.operation = OP_UNUSED;
        end
        return c;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic check_result(input t_res got);
        t_res want;
        if (due_results.size() == 0) begin
            $display("%0t: result with nothing expected, got %h", $time, got);
            err_count++;
        end else begin
            want = due_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("index", want.index, got.index);
            check_field("found_key", want.found_key, got.found_key);
            check_field("found_payload", want.found_payload, got.found_payload);
            check_field("count_after", want.count_after, got.count_after);
            check_field("last", want.last, got.last);
        end
    endtask

    // Result side: random stall per item, then check on acceptance.
    initial begin
        int gap;
        res_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!(res_valid && res_ready));
            check_result(res);
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        forever begin
            @(posedge clk);
            if (rst_n && !(cmd_valid && cmd_ready) && !(res_valid && res_ready))
                stall_cycles++;
            else
                stall_cycles = 0;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic test_empty_list();
        send_op(OP_SEARCH, 0, '0, '0);
        send_op(OP_DELETE, 0, '1, '1);
        send_op(OP_UNUSED, LIST_DEPTH, KEY_MAX, '1);
        send_op(OP_INSERT, 1, 32'd5, 32'h1234_5678);
        send_op(OP_INSERT, LIST_DEPTH, KEY_MIN, '1);
    endtask

    task automatic test_insert_positions();
        send_op(OP_INSERT, 0, KEY_MAX, '1);
        send_op(OP_INSERT, 1, KEY_MIN, '0);
        send_op(OP_INSERT, 0, '0, 32'h5a5a_5a5a);
        send_op(OP_INSERT, 1, KEY_MAX, 32'ha5a5_a5a5);
        send_op(OP_INSERT, 5, 32'd7, 32'd7);
    endtask

    task automatic test_search_delete();
        send_op(OP_SEARCH, 0, KEY_MAX, '0);
        send_op(OP_SEARCH, 0, KEY_MIN, '0);
        send_op(OP_SEARCH, 0, 32'd12345, '0);
        send_op(OP_DELETE, 0, KEY_MAX, '0);
        send_op(OP_DELETE, 0, 32'd12345, '0);
        send_op(OP_SEARCH, 0, KEY_MAX, '0);
        send_op(OP_DELETE, 0, KEY_MIN, '0);
        send_op(OP_UNUSED, 0, '0, '0);
    endtask

    // Fills the list with one key so that a single search returns every entry.
    task automatic test_full_list();
        while (mirror_count > 0) send_op(OP_DELETE, 0, mirror_keys[0], '0);
        repeat (LIST_DEPTH)
            send_op(OP_INSERT, $urandom_range(0, mirror_count), FILL_KEY, $urandom);
        send_op(OP_INSERT, 0, 32'd99, '1);
        send_op(OP_INSERT, LIST_DEPTH, 32'd99, '1);
        send_op(OP_SEARCH, 0, FILL_KEY, '0);
        wait_for_results();
    endtask

    task automatic test_random_mix();
        int seg;
        for (seg = 0; seg < SEG_COUNT; seg++) begin
            tx_idle = seg[0];
            rx_idle = seg[1];
            repeat (SEG_ITEMS) send_cmd(random_cmd(seg[0] ^ seg[2]));
            if (seg == SEG_COUNT / 2) wait_for_results();
        end
    endtask

    initial begin
        err_count    = 0;
        mirror_count = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_insert_positions();
        test_search_delete();
        tx_idle = 1'b0;
        test_full_list();
        test_random_mix();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
